// File: hw/rtl/rils_pkg.sv
// Shared types, constants and hash function for the radix integer literal scanner.
package rils_pkg;

  localparam int VALUE_BITS = 64;
  localparam int HASH_BITS  = 64;
  localparam int RADIX_BITS = 6;
  localparam int CHAR_BITS  = 8;

  localparam logic [HASH_BITS-1:0] FNV_OFFSET = 64'hcbf29ce484222325;

  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LO_Z  = 8'h7a;
  localparam logic [CHAR_BITS-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UP_Z  = 8'h5a;
  localparam logic [CHAR_BITS-1:0] CH_LO_B  = 8'h62;
  localparam logic [CHAR_BITS-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_BITS-1:0] LETTER_OFS = 8'd10;

  localparam logic [RADIX_BITS-1:0] RADIX_BIN = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_OCT = 6'd8;
  localparam logic [RADIX_BITS-1:0] RADIX_DEC = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_HEX = 6'd16;
  localparam logic [RADIX_BITS-1:0] RADIX_B36 = 6'd36;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIGIT = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // Radix used for the current character
  typedef enum logic [1:0] {
    RS_KEEP   = 2'd0,
    RS_TEN    = 2'd1,
    RS_OCT    = 2'd2,
    RS_PREFIX = 2'd3
  } rad_sel_t;

  // Source of the emitted value
  typedef enum logic [1:0] {
    VS_ZERO = 2'd0,
    VS_BASE = 2'd1,
    VS_NEW  = 2'd2
  } val_sel_t;

  typedef struct packed {
    logic zero_char;
    logic dec_digit;
    logic prefix;
    logic alnum;
  } dp_class_t;

  typedef struct packed {
    logic digit_high;
    logic overflow;
  } dp_check_t;

  typedef struct packed {
    logic     step;
    logic     clear;
    logic     mix;
    logic     accum;
    logic     emit;
    val_sel_t val_sel;
    status_t  status;
  } dp_cmd_t;

  // One FNV-1a round; the prime 2^40 + 0x1b3 as shifts and adds
  function automatic logic [HASH_BITS-1:0] fnv_mix(input logic [HASH_BITS-1:0] h,
                                                   input logic [CHAR_BITS-1:0] c);
    logic [HASH_BITS-1:0] x;
    x = h ^ {{(HASH_BITS-CHAR_BITS){1'b0}}, c};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// File: hw/rtl/rils_if.sv
// Valid/ready channel interfaces for characters in and scan results out.
interface rils_in_if;
  import rils_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] character;
  logic                 starts_literal;
  logic                 input_ends;

  modport source (output valid, output character, output starts_literal,
                  output input_ends, input ready);
  modport sink   (input valid, input character, input starts_literal,
                  input input_ends, output ready);
endinterface

interface rils_out_if;
  import rils_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] literal_value;
  logic [HASH_BITS-1:0]  text_hash;
  logic [RADIX_BITS-1:0] base;
  status_t               status;

  modport source (output valid, output literal_value, output text_hash,
                  output base, output status, input ready);
  modport sink   (input valid, input literal_value, input text_hash,
                  input base, input status, output ready);
endinterface

// File: hw/rtl/rils_ctrl.sv
// Phase state machine and handshake control of the literal scanner.
module rils_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                starts_literal,
  input  logic                input_ends,
  output logic                out_valid,
  input  logic                out_ready,
  input  rils_pkg::dp_class_t cls,
  input  rils_pkg::dp_check_t chk,
  output rils_pkg::rad_sel_t  sel,
  output rils_pkg::dp_cmd_t   cmd
);
  import rils_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_ZERO   = 3'b010,
    PH_DIGITS = 3'b100
  } phase_t;

  phase_t phase, phase_next;
  logic   accept;
  logic   take;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Radix choice and digit-path decision depend on starts_literal, the phase and the character class
  always_comb begin
    sel  = RS_KEEP;
    take = 1'b0;
    if (starts_literal) begin
      sel  = RS_TEN;
      take = !cls.zero_char;
    end else begin
      unique case (phase)
        PH_ZERO: begin
          if (cls.prefix) begin
            sel = RS_PREFIX;
          end else begin
            sel  = cls.dec_digit ? RS_OCT : RS_KEEP;
            take = 1'b1;
          end
        end
        PH_DIGITS: take = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.val_sel = VS_ZERO;
    cmd.status  = ST_OK;
    phase_next  = phase;
    if (accept) begin
      cmd.step  = 1'b1;
      cmd.clear = starts_literal;
      if (take) begin
        phase_next = PH_DIGITS;
        if (!cls.alnum) begin
          // terminator: literal ends, character not hashed
          cmd.emit    = 1'b1;
          cmd.val_sel = VS_BASE;
        end else begin
          cmd.mix = 1'b1;
          if (chk.digit_high) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_BAD_DIGIT;
          end else if (chk.overflow) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_OVERFLOW;
          end else begin
            cmd.accum = 1'b1;
            if (input_ends) begin
              cmd.emit    = 1'b1;
              cmd.val_sel = VS_NEW;
            end
          end
        end
      end else if (starts_literal) begin
        // leading zero
        cmd.mix    = 1'b1;
        phase_next = PH_ZERO;
        cmd.emit   = input_ends;
      end else if (phase == PH_ZERO) begin
        // radix prefix character
        cmd.mix    = 1'b1;
        phase_next = PH_DIGITS;
        cmd.emit   = input_ends;
      end
      if (cmd.emit) begin
        phase_next = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/rils_dpath.sv
// Character decode, radix accumulator, FNV-1a hash and result register.
module rils_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [rils_pkg::CHAR_BITS-1:0]      character,
  input  rils_pkg::rad_sel_t                  sel,
  input  rils_pkg::dp_cmd_t                   cmd,
  output rils_pkg::dp_class_t                 cls,
  output rils_pkg::dp_check_t                 chk,
  output logic [rils_pkg::VALUE_BITS-1:0]     literal_value,
  output logic [rils_pkg::HASH_BITS-1:0]      text_hash,
  output logic [rils_pkg::RADIX_BITS-1:0]     base,
  output rils_pkg::status_t                   status
);
  import rils_pkg::*;

  localparam int WIDE_BITS = VALUE_BITS + RADIX_BITS;

  logic [RADIX_BITS-1:0] radix;
  logic [VALUE_BITS-1:0] acc;
  logic [HASH_BITS-1:0]  hash;

  logic                  is_dec, is_lower, is_upper;
  logic [CHAR_BITS-1:0]  digit_wide;
  logic [RADIX_BITS-1:0] digit;
  logic [RADIX_BITS-1:0] eff_radix;
  logic [VALUE_BITS-1:0] acc_base;
  logic [HASH_BITS-1:0]  hash_base;
  logic [HASH_BITS-1:0]  hash_mixed;
  logic [WIDE_BITS-1:0]  wide;
  logic [WIDE_BITS-1:0]  scaled;
  logic [WIDE_BITS-1:0]  prod;
  logic [VALUE_BITS-1:0] acc_new;
  logic [VALUE_BITS-1:0] value_out;

  // character class
  assign is_dec   = (character >= CH_ZERO) && (character <= CH_NINE);
  assign is_lower = (character >= CH_LO_A) && (character <= CH_LO_Z);
  assign is_upper = (character >= CH_UP_A) && (character <= CH_UP_Z);

  always_comb begin
    if (is_dec) begin
      digit_wide = character - CH_ZERO;
    end else if (is_lower) begin
      digit_wide = character - CH_LO_A + LETTER_OFS;
    end else if (is_upper) begin
      digit_wide = character - CH_UP_A + LETTER_OFS;
    end else begin
      digit_wide = '0;
    end
  end
  assign digit = digit_wide[RADIX_BITS-1:0];

  assign cls.zero_char = (character == CH_ZERO);
  assign cls.dec_digit = is_dec;
  assign cls.prefix    = (character == CH_LO_B) || (character == CH_LO_X) ||
                         (character == CH_HASH);
  assign cls.alnum     = is_dec || is_lower || is_upper;

  always_comb begin
    unique case (sel)
      RS_TEN:    eff_radix = RADIX_DEC;
      RS_OCT:    eff_radix = RADIX_OCT;
      RS_PREFIX: begin
        if (character == CH_LO_B) begin
          eff_radix = RADIX_BIN;
        end else if (character == CH_LO_X) begin
          eff_radix = RADIX_HEX;
        end else begin
          eff_radix = RADIX_B36;
        end
      end
      default:   eff_radix = radix;
    endcase
  end

  assign acc_base  = cmd.clear ? '0 : acc;
  assign hash_base = cmd.clear ? FNV_OFFSET : hash;

  // acc * radix as shifts and adds, kept wide for the overflow check
  assign wide = {{RADIX_BITS{1'b0}}, acc_base};
  always_comb begin
    case (eff_radix)
      RADIX_BIN: scaled = wide << 1;
      RADIX_OCT: scaled = wide << 3;
      RADIX_HEX: scaled = wide << 4;
      RADIX_B36: scaled = (wide << 5) + (wide << 2);
      default:   scaled = (wide << 3) + (wide << 1);
    endcase
  end
  assign prod    = scaled + {{(WIDE_BITS-RADIX_BITS){1'b0}}, digit};
  assign acc_new = prod[VALUE_BITS-1:0];

  assign chk.overflow   = |prod[WIDE_BITS-1:VALUE_BITS];
  assign chk.digit_high = (digit >= eff_radix);

  assign hash_mixed = fnv_mix(hash_base, character);

  always_comb begin
    case (cmd.val_sel)
      VS_BASE: value_out = acc_base;
      VS_NEW:  value_out = acc_new;
      default: value_out = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_DEC;
      acc   <= '0;
      hash  <= FNV_OFFSET;
    end else if (cmd.step) begin
      radix <= eff_radix;
      acc   <= cmd.accum ? acc_new : acc_base;
      hash  <= cmd.mix ? hash_mixed : hash_base;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      literal_value <= value_out;
      text_hash     <= cmd.mix ? hash_mixed : hash_base;
      base          <= eff_radix;
      status        <= cmd.status;
    end
  end

endmodule

// File: hw/rtl/radix_integer_literal_scanner.sv
// Top level of the radix integer literal scanner: controller plus datapath.
//
// Scans an integer literal one character per transaction on chars and
// returns one result transaction on results when the literal ends: at a
// terminator (not hashed), on a bad digit or overflow, or on a character
// flagged input_ends. A leading 0 then b, x or # picks radix 2, 16 or 36;
// a leading 0 then a decimal digit picks octal; otherwise radix 10. The
// result carries the value (0 on error), the 64-bit FNV-1a hash of the
// literal characters, the radix and a status code (ok, bad digit,
// overflow). The radix multiply and the FNV prime multiply are both
// constant shift-and-add networks ahead of the state registers, so a
// new character can be taken every cycle while chars.ready is high.
// Results go through a one-deep output register; chars.ready
// stays high while that register is empty or is being drained in the same
// cycle, so a stalled results sink holds off input only once a result is
// waiting.
module radix_integer_literal_scanner (
  input logic       clk,
  input logic       rst,
  rils_in_if.sink   chars,
  rils_out_if.source results
);
  import rils_pkg::*;

  dp_class_t cls;
  dp_check_t chk;
  rad_sel_t  sel;
  dp_cmd_t   cmd;

  // sequencing: phase tracking, what to do with each transaction
  rils_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (chars.valid),
    .in_ready       (chars.ready),
    .starts_literal (chars.starts_literal),
    .input_ends     (chars.input_ends),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .cls            (cls),
    .chk            (chk),
    .sel            (sel),
    .cmd            (cmd)
  );

  // decode, accumulate, hash and hold the result payload
  rils_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .character     (chars.character),
    .sel           (sel),
    .cmd           (cmd),
    .cls           (cls),
    .chk           (chk),
    .literal_value (results.literal_value),
    .text_hash     (results.text_hash),
    .base          (results.base),
    .status        (results.status)
  );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the radix integer literal scanner.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rils_pkg::*;

  // Run limit in clock cycles.
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [63:0] HASH_MULT    = 64'h0000_0100_0000_01b3;
  localparam logic [63:0] VALUE_MAX    = {VALUE_BITS{1'b1}};
  localparam logic [7:0]  NO_DIGIT     = 8'hff;

  // Scanner phase as tracked by the predictor.
  typedef enum logic [1:0] {
    SCAN_IDLE   = 2'd0,
    SCAN_ZERO   = 2'd1,
    SCAN_DIGITS = 2'd2
  } scan_phase_t;

  // One expected result transaction.
  typedef struct {
    logic [63:0] value;
    logic [63:0] hash;
    logic [5:0]  base;
    status_t     status;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rils_in_if  chars_if ();
  rils_out_if results_if ();

  radix_integer_literal_scanner i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  always #2 clk = ~clk;

  // Predictor state: mirrors the scanner's registers.
  scan_phase_t  lit_phase;
  logic [5:0]   lit_radix;
  logic [63:0]  lit_value;
  logic [63:0]  lit_hash;
  scan_result_t expected_results[$];

  int mismatches   = 0;
  int result_count = 0;
  int items_taken  = 0;   // transactions the scanner actually acts on
  int cycle_count  = 0;

  // Sender burst/gap control.
  bit gaps_on    = 1'b1;
  int burst_left = 0;

  // Receiver long hold-off: requested by a test, counted down by the receiver.
  int hold_req  = 0;
  int hold_left = 0;
  int rx_tick   = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // 0-9 for decimal digits, 10-35 for letters of either case, NO_DIGIT otherwise.
  function automatic logic [7:0] digit_value(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_LO_A && c <= CH_LO_Z) return c - CH_LO_A + LETTER_OFS;
    if (c >= CH_UP_A && c <= CH_UP_Z) return c - CH_UP_A + LETTER_OFS;
    return NO_DIGIT;
  endfunction

  // One FNV-1a round: xor the byte in, then multiply by the 64-bit prime.
  function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] c);
    return (h ^ {56'd0, c}) * HASH_MULT;
  endfunction

  // Queue a result; any result sends the scanner back to idle.
  task automatic post_result(logic [63:0] value, status_t st);
    scan_result_t r;
    r = '{value: value, hash: lit_hash, base: lit_radix, status: st};
    expected_results.push_back(r);
    lit_phase = SCAN_IDLE;
  endtask

  // A character in digit position. A non-alphanumeric one terminates the
  // literal without being hashed; anything else is hashed before the checks.
  task automatic accept_digit(logic [7:0] c, bit ends);
    logic [7:0] d;
    d = digit_value(c);
    if (d == NO_DIGIT) begin
      post_result(lit_value, ST_OK);
    end else begin
      lit_hash = fnv_step(lit_hash, c);
      if (d >= {2'b00, lit_radix}) begin
        post_result('0, ST_BAD_DIGIT);
      end else if (lit_value > (VALUE_MAX - 64'(d)) / 64'(lit_radix)) begin
        post_result('0, ST_OVERFLOW);
      end else begin
        lit_value = lit_value * 64'(lit_radix) + 64'(d);
        if (ends) post_result(lit_value, ST_OK);
      end
    end
  endtask

  task automatic predict_char(logic [7:0] c, bit start, bit ends);
    logic [5:0] prefix_radix;
    if (start) begin
      // A start always abandons whatever literal was in progress.
      lit_radix = RADIX_DEC;
      lit_value = '0;
      lit_hash  = FNV_OFFSET;
      if (c == CH_ZERO) begin
        lit_hash  = fnv_step(lit_hash, c);
        lit_phase = SCAN_ZERO;
        if (ends) post_result('0, ST_OK);
      end else begin
        lit_phase = SCAN_DIGITS;
        accept_digit(c, ends);
      end
    end else if (lit_phase == SCAN_ZERO) begin
      case (c)
        CH_LO_B: prefix_radix = RADIX_BIN;
        CH_LO_X: prefix_radix = RADIX_HEX;
        CH_HASH: prefix_radix = RADIX_B36;
        default: prefix_radix = '0;
      endcase
      if (prefix_radix != '0) begin
        lit_radix = prefix_radix;
        lit_hash  = fnv_step(lit_hash, c);
        lit_phase = SCAN_DIGITS;
        if (ends) post_result('0, ST_OK);
      end else begin
        // Leading zero then a decimal digit: octal, the zero counts as a digit.
        if (c >= CH_ZERO && c <= CH_NINE) lit_radix = RADIX_OCT;
        lit_phase = SCAN_DIGITS;
        accept_digit(c, ends);
      end
    end else if (lit_phase == SCAN_DIGITS) begin
      accept_digit(c, ends);
    end
    // Idle without a start: the character is dropped, nothing expected.
  endtask

  // ---------------------------------------------------------------------------
  // Driving side
  // ---------------------------------------------------------------------------

  // Offer one character transaction, with an optional idle gap ahead of it.
  // Inputs move on the falling edge; acceptance is seen on the rising edge.
  task automatic send_char(logic [7:0] c, bit start, bit ends);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      chars_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    chars_if.valid          <= 1'b1;
    chars_if.character      <= c;
    chars_if.starts_literal <= start;
    chars_if.input_ends     <= ends;
    do @(posedge clk); while (chars_if.ready !== 1'b1);
    if (start || lit_phase != SCAN_IDLE) items_taken++;
    predict_char(c, start, ends);
  endtask

  // A literal written as text: start on the first character, optional end flag
  // on the last.
  task automatic send_text(string s, bit ends_last);
    int i;
    for (i = 0; i < s.len(); i++)
      send_char(s[i], i == 0, ends_last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] digit_char(logic [5:0] d, bit upper);
    if (d < 6'd10) return CH_ZERO + 8'(d);
    return (upper ? CH_UP_A : CH_LO_A) + 8'(d) - LETTER_OFS;
  endfunction

  // Any byte that is neither a letter nor a digit, high bit included.
  function automatic logic [7:0] pick_terminator();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (digit_value(c) != NO_DIGIT);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiving side: own stall pattern plus long hold-offs on request
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    rx_tick++;
    if (rst) begin
      results_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      results_if.ready <= 1'b0;
    end else begin
      // Mode rotates with rx_tick: always ready, coin flip, sparse, mostly ready.
      case ((rx_tick / 150) % 4)
        0:       results_if.ready <= 1'b1;
        1:       results_if.ready <= ($urandom_range(0, 1) == 0);
        2:       results_if.ready <= (rx_tick % 5 == 0);
        default: results_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR result %0d %s: got %h, want %h", result_count, what, got, want);
    mismatches++;
  endtask

  // Every result transaction is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    scan_result_t want;
    if (!rst && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("with none expected, value", results_if.literal_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (results_if.literal_value !== want.value)
          report_mismatch("literal_value", results_if.literal_value, want.value);
        if (results_if.text_hash !== want.hash)
          report_mismatch("text_hash", results_if.text_hash, want.hash);
        if (results_if.base !== want.base)
          report_mismatch("base", 64'(results_if.base), 64'(want.base));
        if (results_if.status !== want.status)
          report_mismatch("status", 64'(results_if.status), 64'(want.status));
      end
      result_count++;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Binary, base 36 and octal literals, plus hex and base 36 prefixes with
  // no digits behind them, closed both by a terminator and by end of input.
  task automatic test_radix_prefixes();
    send_text("0b1 ", 1'b0);
    send_text("0#Zz", 1'b1);
    send_text("07", 1'b1);
    send_text("0x", 1'b1);
    send_text("0#-", 1'b0);
  endtask

  // Corner behavior around the first characters of a literal.
  task automatic test_special_cases();
    send_text("08", 1'b0);       // octal with a digit that is too big
    send_text("0,", 1'b0);       // lone zero, terminated
    send_text("0", 1'b1);        // lone zero at end of input
    send_text("0q", 1'b0);       // zero then a non-prefix letter
    send_text("k", 1'b0);        // start on a letter: bad decimal digit
    send_text("+", 1'b0);        // start on a non-digit: empty literal
    send_char("5", 1'b0, 1'b0);  // idle, no start: dropped
    send_text("9", 1'b0);        // abandoned by the next start
    send_text("2", 1'b1);
  endtask

  // Receiver holds off for a long stretch while short literals keep coming,
  // so the output register fills and the scanner must stall its input.
  task automatic test_output_backpressure();
    int n;
    gaps_on  = 1'b0;
    hold_req = 120;
    for (n = 0; n < 12; n++) begin
      send_char(digit_char(6'($urandom_range(0, 9)), 1'b0), 1'b1, 1'b0);
      send_char(";", 1'b0, 1'b0);
    end
    gaps_on = 1'b1;
  endtask

  // Random bytes with random flags; mostly ignored or short broken literals.
  task automatic send_noise();
    int n;
    int k;
    n = $urandom_range(1, 4);
    for (k = 0; k < n; k++)
      send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                $urandom_range(0, 3) == 0);
  endtask

  // A well-formed literal of a random value in a random radix, now and then
  // with an extra digit (overflow near the top), a stray alphanumeric
  // character, and a terminator, an end flag or no ending at all.
  task automatic send_random_literal();
    logic [5:0]  radix;
    logic [63:0] v;
    logic [7:0]  text[$];
    int          term;
    int          prefix_len;
    int          i;
    case ($urandom_range(0, 4))
      0:       radix = RADIX_BIN;
      1:       radix = RADIX_OCT;
      2:       radix = RADIX_HEX;
      3:       radix = RADIX_B36;
      default: radix = RADIX_DEC;
    endcase
    case ($urandom_range(0, 9))
      0:       v = VALUE_MAX;
      1:       v = {$urandom, $urandom};
      2:       v = '0;
      default: v = {$urandom, $urandom} >> $urandom_range(32, 63);
    endcase
    case (radix)
      RADIX_BIN: text = '{CH_ZERO, CH_LO_B};
      RADIX_HEX: text = '{CH_ZERO, CH_LO_X};
      RADIX_B36: text = '{CH_ZERO, CH_HASH};
      RADIX_OCT: text = '{CH_ZERO};
      default:   text = {};
    endcase
    prefix_len = text.size();
    do begin
      text.insert(prefix_len, digit_char(6'(v % 64'(radix)), $urandom_range(0, 1)));
      v = v / 64'(radix);
    end while (v != '0);
    if ($urandom_range(0, 5) == 0)
      text.push_back(digit_char(6'($urandom_range(0, radix - 1)), $urandom_range(0, 1)));
    if ($urandom_range(0, 9) == 0)
      text[$urandom_range(0, text.size() - 1)] =
        digit_char(6'($urandom_range(0, 35)), $urandom_range(0, 1));
    term = $urandom_range(0, 3);
    for (i = 0; i < text.size(); i++)
      send_char(text[i], i == 0, term == 2 && i == text.size() - 1);
    if (term < 2)
      send_char(pick_terminator(), 1'b0, $urandom_range(0, 3) == 0);
  endtask

  task automatic test_random_literals();
    int goal;
    goal = items_taken + 600;
    while (items_taken < goal) begin
      // Some literals go out back to back with no sender gaps at all.
      gaps_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_random_literal();
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    chars_if.valid          = 1'b0;
    chars_if.character      = '0;
    chars_if.starts_literal = 1'b0;
    chars_if.input_ends     = 1'b0;
    results_if.ready        = 1'b0;
    lit_phase = SCAN_IDLE;
    lit_radix = RADIX_DEC;
    lit_value = '0;
    lit_hash  = FNV_OFFSET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_radix_prefixes();
    test_special_cases();
    test_output_backpressure();
    test_random_literals();

    @(negedge clk);
    chars_if.valid <= 1'b0;
    // Drain: every expected transaction must arrive, then a few quiet cycles
    // to catch anything extra.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
